/* rtl/fvm_pkg.sv */
// Shared constants and types for the FOC voltage modulator.
`timescale 1ns / 1ps
`default_nettype none

package fvm_pkg;

    // Commanded voltage held doubled, as a signed Q.9 value.
    localparam int UQ_W  = 17;
    // Signed Q16 sine and cosine in [-65536, 65536].
    localparam int SIN_W = 18;
    // Doubled phase voltages in signed Q.41 volts.
    localparam int NUM_W = 52;

    localparam logic [16:0] COEF_A    = 17'd102944;
    localparam logic [15:0] COEF_B    = 16'd42048;
    localparam logic [12:0] COEF_C    = 13'd4640;
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;
    localparam logic [15:0] BUS_RESET = 16'd3072;

    // Polynomial argument for one quarter turn, and the sign of the quadrant.
    typedef struct packed {
        logic        neg;
        logic [16:0] x;
    } sine_in_t;

endpackage

`default_nettype wire

/* rtl/fvm_sine.sv */
// Four-stage pipelined polynomial sine evaluator for one quarter turn.
`timescale 1ns / 1ps
`default_nettype none

module fvm_sine
    import fvm_pkg::*;
(
    input  wire logic                    clk,
    input  wire sine_in_t                arg,
    output logic signed [SIN_W-1:0]      sine
);

    logic [16:0]             x1_reg;
    logic                    neg1_reg;
    logic [16:0]             x2_1_reg;
    logic [16:0]             x2_next;

    logic [16:0]             x2_reg;
    logic                    neg2_reg;
    logic [16:0]             x2_2_reg;
    logic [15:0]             t2_reg;
    logic [15:0]             t2_next;

    logic [16:0]             x3_reg;
    logic                    neg3_reg;
    logic [16:0]             t4_reg;
    logic [16:0]             t4_next;

    logic signed [SIN_W-1:0] sine_reg;
    logic signed [SIN_W-1:0] sine_next;

    logic [33:0]             sq_prod;
    logic [29:0]             c_prod;
    logic [32:0]             b_prod;
    logic [33:0]             a_prod;
    logic [17:0]             s_raw;
    logic [16:0]             s_cap;

    // Stage one squares the argument.
    always_comb
    begin
        sq_prod = 34'(arg.x) * 34'(arg.x);
        x2_next = sq_prod[32:16];
    end

    // Stage two and three evaluate the inner Horner terms.
    always_comb
    begin
        c_prod  = 30'(x2_1_reg) * 30'(COEF_C);
        t2_next = COEF_B - 16'(c_prod[29:16]);
        b_prod  = 33'(t2_reg) * 33'(x2_2_reg);
        t4_next = COEF_A - b_prod[32:16];
    end

    // Stage four multiplies by the argument, caps at one and applies the quadrant sign.
    always_comb
    begin
        a_prod    = 34'(t4_reg) * 34'(x3_reg);
        s_raw     = a_prod[33:16];
        s_cap     = (s_raw > 18'(ONE_Q16)) ? ONE_Q16 : s_raw[16:0];
        sine_next = neg3_reg ? -$signed({1'b0, s_cap}) : $signed({1'b0, s_cap});
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= arg.x;
        neg1_reg <= arg.neg;
        x2_1_reg <= x2_next;

        x2_reg   <= x1_reg;
        neg2_reg <= neg1_reg;
        x2_2_reg <= x2_1_reg;
        t2_reg   <= t2_next;

        x3_reg   <= x2_reg;
        neg3_reg <= neg2_reg;
        t4_reg   <= t4_next;

        sine_reg <= sine_next;
    end

    assign sine = sine_reg;

endmodule

`default_nettype wire

/* rtl/fvm_duty.sv */
// Pipelined duty scaler: saturation, scaling and a one-bit-per-stage divider.
`timescale 1ns / 1ps
`default_nettype none

module fvm_duty
    import fvm_pkg::*;
#(
    parameter int DUTY_BITS = 8
)
(
    input  wire logic                     clk,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic [15:0]              bus,
    output logic [DUTY_BITS-1:0]          duty
);

    localparam int Q_W    = NUM_W - 16;
    localparam int MW     = 16 + DUTY_BITS;
    localparam int SCL_W  = Q_W + DUTY_BITS;

    logic [Q_W-1:0]          q;
    logic [SCL_W-1:0]        scaled;
    logic                    zero_next;
    logic                    sat_next;

    logic [MW-1:0]           rem_reg  [0:DUTY_BITS];
    logic [DUTY_BITS-1:0]    quot_reg [0:DUTY_BITS];
    logic                    zero_reg [0:DUTY_BITS];
    logic                    sat_reg  [0:DUTY_BITS];

    logic [MW-1:0]           rem_next  [0:DUTY_BITS-1];
    logic [DUTY_BITS-1:0]    quot_next [0:DUTY_BITS-1];

    // The divisor bus << 18 is folded into the dividend, leaving a division by bus alone.
    always_comb
    begin
        q         = num[NUM_W-1:16];
        zero_next = num[NUM_W-1] || (num == '0);
        sat_next  = (q >= {2'b00, bus, 18'd0});
        scaled    = {q, DUTY_BITS'(0)} - SCL_W'(q);
    end

    always_comb
    begin
        logic [MW-1:0] trial;
        logic          ge;
        for (int j = 0; j < DUTY_BITS; j++)
        begin
            trial        = MW'(bus) << (DUTY_BITS - 1 - j);
            ge           = (rem_reg[j] >= trial);
            rem_next[j]  = ge ? rem_reg[j] - trial : rem_reg[j];
            quot_next[j] = {quot_reg[j][DUTY_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= scaled[18 +: MW];
        quot_reg[0] <= '0;
        zero_reg[0] <= zero_next;
        sat_reg[0]  <= sat_next;
        for (int j = 0; j < DUTY_BITS; j++)
        begin
            rem_reg[j+1]  <= rem_next[j];
            quot_reg[j+1] <= quot_next[j];
            zero_reg[j+1] <= zero_reg[j];
            sat_reg[j+1]  <= sat_reg[j];
        end
    end

    assign duty = zero_reg[DUTY_BITS] ? '0 :
                  sat_reg[DUTY_BITS]  ? '1 : quot_reg[DUTY_BITS];

endmodule

`default_nettype wire

/* rtl/foc_voltage_modulator_unit.sv */
// Top level of the FOC voltage modulator: clamp, inverse Park and Clarke, duty scaling.
//
// A command is transferred on a rising edge with start high; busy is always low, so
// one command may be transferred on every clock cycle. Each command carries the
// quadrature voltage quad_voltage (signed Q8.8) and the angle elec_angle (a fraction
// of a turn). The bus voltage register is written through cfg_we and cfg_wdata and
// should only change while no command is in flight.
// Every command yields exactly one result: duty_a, duty_b, duty_c and cmd_clamped
// are valid for the single cycle in which done is high, and are transferred at the
// edge that ends that cycle. Between the command and its result lie the sine
// polynomial, the two voltage multipliers and the divider, which retires one
// quotient bit per stage. Throughput is one command per cycle.
// The receiver cannot stall the block, and none is needed since results stream out
// in order. Reset clears the pipeline valid bits, so no stale result appears, and
// sets the bus voltage to 12 V.
`timescale 1ns / 1ps
`default_nettype none

module foc_voltage_modulator_unit
    import fvm_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int DUTY_BITS  = 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] quad_voltage,
    input  wire logic [15:0]        elec_angle,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    output logic                    done,
    output logic [7:0]              duty_a,
    output logic [7:0]              duty_b,
    output logic [7:0]              duty_c,
    output logic                    cmd_clamped
);

    localparam int LAT = DUTY_BITS + 10;
    localparam int SHL = (ANGLE_BITS <= 18) ? 18 - ANGLE_BITS : 0;
    localparam int SHR = (ANGLE_BITS > 18) ? ANGLE_BITS - 18 : 0;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic [15:0]               bus_reg;

    logic [LAT-1:0]            vld_reg;
    logic [LAT-1:0]            clamp_reg;
    logic signed [UQ_W-1:0]    uq_reg [0:4];

    logic signed [UQ_W-1:0]    uq2;
    logic signed [UQ_W-1:0]    bus_s;
    logic signed [UQ_W-1:0]    uq_next;
    logic                      clamp_next;
    logic                      take;

    logic [ANGLE_BITS-1:0]     ang;
    sine_in_t                  sin_arg_next;
    sine_in_t                  cos_arg_next;
    sine_in_t                  sin_arg_reg;
    sine_in_t                  cos_arg_reg;
    logic signed [SIN_W-1:0]   sin_val;
    logic signed [SIN_W-1:0]   cos_val;

    logic signed [34:0]        alpha_reg;
    logic signed [34:0]        beta_reg;
    logic signed [34:0]        alpha_next;
    logic signed [34:0]        beta_next;
    logic signed [34:0]        alpha6_reg;
    logic signed [NUM_W-1:0]   beta41_reg;
    logic signed [NUM_W-1:0]   beta41_next;

    logic signed [NUM_W-1:0]   alpha41;
    logic signed [NUM_W-1:0]   bus41;
    logic signed [NUM_W-1:0]   na_reg;
    logic signed [NUM_W-1:0]   nb_reg;
    logic signed [NUM_W-1:0]   nc_reg;
    logic signed [NUM_W-1:0]   na_next;
    logic signed [NUM_W-1:0]   nb_next;
    logic signed [NUM_W-1:0]   nc_next;

    logic [DUTY_BITS-1:0]      da;
    logic [DUTY_BITS-1:0]      db;
    logic [DUTY_BITS-1:0]      dc;
    logic [7:0]                duty_a_reg;
    logic [7:0]                duty_b_reg;
    logic [7:0]                duty_c_reg;

    // Splits an angle into the polynomial argument of its quarter turn.
    function automatic sine_in_t angle_arg(input logic [ANGLE_BITS-1:0] a);
        sine_in_t    r;
        logic [23:0] frac_ext;
        logic [16:0] x;
        frac_ext = 24'(a[ANGLE_BITS-3:0]);
        x        = 17'((frac_ext << SHL) >> SHR);
        r.x      = a[ANGLE_BITS-2] ? ONE_Q16 - x : x;
        r.neg    = a[ANGLE_BITS-1];
        return r;
    endfunction

    assign busy = 1'b0;
    assign take = start && !busy;

    // Clamp the doubled command against the bus voltage, which avoids halving it.
    always_comb
    begin
        uq2        = {quad_voltage, 1'b0};
        bus_s      = $signed({1'b0, bus_reg});
        uq_next    = uq2;
        clamp_next = 1'b0;
        if (uq2 > bus_s)
        begin
            uq_next    = bus_s;
            clamp_next = 1'b1;
        end
        else if (uq2 < -bus_s)
        begin
            uq_next    = -bus_s;
            clamp_next = 1'b1;
        end
        ang          = ANGLE_BITS'(elec_angle);
        sin_arg_next = angle_arg(ang);
        cos_arg_next = angle_arg(ang + QUARTER);
    end

    fvm_sine u_sin
    (
        .clk  (clk),
        .arg  (sin_arg_reg),
        .sine (sin_val)
    );

    fvm_sine u_cos
    (
        .clk  (clk),
        .arg  (cos_arg_reg),
        .sine (cos_val)
    );

    always_comb
    begin
        alpha_next  = -(35'(uq_reg[4]) * 35'(sin_val));
        beta_next   = 35'(uq_reg[4]) * 35'(cos_val);
        beta41_next = NUM_W'(beta_reg) * $signed(NUM_W'(SQRT3_Q16));
    end

    // Inverse Clarke on the doubled voltages, with the bus midpoint added.
    always_comb
    begin
        alpha41 = NUM_W'(alpha6_reg) <<< 16;
        bus41   = $signed(NUM_W'(bus_reg)) <<< 33;
        na_next = (alpha41 <<< 1) + bus41;
        nb_next = beta41_reg - alpha41 + bus41;
        nc_next = -alpha41 - beta41_reg + bus41;
    end

    fvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_a
    (
        .clk  (clk),
        .num  (na_reg),
        .bus  (bus_reg),
        .duty (da)
    );

    fvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_b
    (
        .clk  (clk),
        .num  (nb_reg),
        .bus  (bus_reg),
        .duty (db)
    );

    fvm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_c
    (
        .clk  (clk),
        .num  (nc_reg),
        .bus  (bus_reg),
        .duty (dc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg    <= BUS_RESET;
            vld_reg    <= '0;
            duty_a_reg <= '0;
            duty_b_reg <= '0;
            duty_c_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bus_reg <= cfg_wdata;
            end
            vld_reg <= {vld_reg[LAT-2:0], take};
            // Output registers only load on a live transfer so they hold between results.
            if (vld_reg[LAT-2])
            begin
                duty_a_reg <= 8'(da);
                duty_b_reg <= 8'(db);
                duty_c_reg <= 8'(dc);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clamp_reg   <= {clamp_reg[LAT-2:0], clamp_next};
        uq_reg[0]   <= uq_next;
        for (int i = 1; i < 5; i++)
        begin
            uq_reg[i] <= uq_reg[i-1];
        end
        sin_arg_reg <= sin_arg_next;
        cos_arg_reg <= cos_arg_next;
        alpha_reg   <= alpha_next;
        beta_reg    <= beta_next;
        alpha6_reg  <= alpha_reg;
        beta41_reg  <= beta41_next;
        na_reg      <= na_next;
        nb_reg      <= nb_next;
        nc_reg      <= nc_next;
    end

    assign done        = vld_reg[LAT-1];
    assign cmd_clamped = clamp_reg[LAT-1];
    assign duty_a      = duty_a_reg;
    assign duty_b      = duty_b_reg;
    assign duty_c      = duty_c_reg;

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, LAT))
        else $error("result without a matching command transfer");

    a_clamp_flag_travels: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cmd_clamped == $past(clamp_next, LAT)))
        else $error("clamp flag does not match its command");

    a_zero_cmd_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(take && (quad_voltage == 16'sd0), LAT))
            |-> ((duty_a == duty_b) && (duty_b == duty_c)))
        else $error("zero command gave unequal phase duties");

    a_duty_held: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[LAT-2] |=> $stable({duty_a, duty_b, duty_c}))
        else $error("duty outputs changed without a result");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the FOC voltage modulator: clamp, inverse transforms and duties.
`timescale 1ns / 1ps

module tb_top;
    import fvm_pkg::*;

    localparam int LATENCY    = 18;
    localparam int SETTLE     = LATENCY + 12;
    localparam int LIMIT      = 200000;
    localparam int REPORT_MAX = 10;

    localparam longint POLY_A   = 102944;
    localparam longint POLY_B   = 42048;
    localparam longint POLY_C   = 4640;
    localparam longint ROOT3    = 113512;
    localparam longint UNIT_Q16 = 65536;
    localparam longint DUTY_TOP = 255;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic       clamped;
    } duty_set_t;

    typedef enum logic {
        ROW_BUS,
        ROW_CMD
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        logic [15:0] ang;
        bit          typed;
        duty_set_t   want;
    } stim_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    logic [15:0] quad_voltage = 16'd0;
    logic [15:0] elec_angle   = 16'd0;
    logic        cfg_we       = 1'b0;
    logic [15:0] cfg_wdata    = 16'd0;
    logic        busy;
    logic        done;
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
    logic [7:0]  duty_c;
    logic        cmd_clamped;

    // Expectation carried alongside start for rows whose result is typed in.
    bit          typed_next = 1'b0;
    duty_set_t   typed_want = '0;

    logic [15:0] model_bus = BUS_RESET;
    duty_set_t   pending_duties[$];
    stim_row_t   directed_rows[$];
    int          accepted     = 0;
    int          clamped_seen = 0;
    int          faults       = 0;
    int          bus_settings = 0;

    foc_voltage_modulator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .quad_voltage (quad_voltage),
        .elec_angle   (elec_angle),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .duty_a       (duty_a),
        .duty_b       (duty_b),
        .duty_c       (duty_c),
        .cmd_clamped  (cmd_clamped)
    );

    always #10 clk = ~clk;

    // Quarter-turn polynomial sine in Q16, mirrored into the other quadrants.
    function automatic longint poly_sine(input logic [15:0] ang);
        longint x;
        longint x2;
        longint t;
        longint s;
        x = {48'd0, ang[13:0], 2'b00};
        if (ang[14])
            x = UNIT_Q16 - x;
        x2 = (x * x) >> 16;
        t  = (POLY_C * x2) >> 16;
        t  = POLY_B - t;
        t  = (t * x2) >> 16;
        t  = POLY_A - t;
        s  = (t * x) >> 16;
        if (s > UNIT_Q16)
            s = UNIT_Q16;
        return ang[15] ? -s : s;
    endfunction

    function automatic logic [7:0] phase_duty(input longint n, input longint bus);
        longint q;
        longint den;
        if (n <= 0 || bus == 0)
            return 8'd0;
        q   = n >>> 16;
        den = bus << 18;
        if (q >= den)
            return 8'(DUTY_TOP);
        return 8'((q * DUTY_TOP) / den);
    endfunction

    function automatic duty_set_t modulate(input logic [15:0] qv, input logic [15:0] ang,
                                           input logic [15:0] bus_reg);
        longint    uq;
        longint    bus;
        longint    sn;
        longint    cs;
        longint    alpha41;
        longint    beta41;
        longint    mid41;
        duty_set_t r;
        uq        = longint'($signed(qv)) * 2;
        bus       = {48'd0, bus_reg};
        r.clamped = 1'b0;
        if (uq > bus)
        begin
            uq        = bus;
            r.clamped = 1'b1;
        end
        else if (uq < -bus)
        begin
            uq        = -bus;
            r.clamped = 1'b1;
        end
        sn      = poly_sine(ang);
        cs      = poly_sine(ang + 16'd16384);
        alpha41 = (-uq * sn) * UNIT_Q16;
        beta41  = ROOT3 * (uq * cs);
        mid41   = bus << 33;
        r.a     = phase_duty(2 * alpha41 + mid41, bus);
        r.b     = phase_duty(beta41 - alpha41 + mid41, bus);
        r.c     = phase_duty(-alpha41 - beta41 + mid41, bus);
        return r;
    endfunction

    function automatic void add_bus(input logic [15:0] v);
        stim_row_t r;
        r       = '{kind: ROW_BUS, default: '0};
        r.kind  = ROW_BUS;
        r.value = v;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cmd(input logic [15:0] q, input logic [15:0] ang);
        stim_row_t r;
        r       = '{kind: ROW_CMD, default: '0};
        r.kind  = ROW_CMD;
        r.value = q;
        r.ang   = ang;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input logic [15:0] q, input logic [15:0] ang,
                                      input duty_set_t want);
        stim_row_t r;
        r       = '{kind: ROW_CMD, default: '0};
        r.kind  = ROW_CMD;
        r.value = q;
        r.ang   = ang;
        r.typed = 1'b1;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    task automatic report_fault(input string msg);
        if (faults < REPORT_MAX)
            $display("Mismatch at %0t: %s", $realtime, msg);
        faults++;
    endtask

    // Offers one command and holds it until transferred, then idles at random.
    task automatic issue(input logic [15:0] q, input logic [15:0] ang, input bit typed,
                         input duty_set_t want, input int idle_pct);
        start        <= 1'b1;
        quad_voltage <= q;
        elec_angle   <= ang;
        typed_next   <= typed;
        typed_want   <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
            begin
                quad_voltage <= 16'($urandom);
                elec_angle   <= 16'($urandom);
                @(posedge clk);
            end
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // The bus voltage is only changed once every outstanding result has arrived.
    task automatic set_bus(input logic [15:0] v);
        start <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        bus_settings++;
    endtask

    always @(posedge clk)
    begin : result_monitor
        duty_set_t got;
        duty_set_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{duty_a, duty_b, duty_c, cmd_clamped};
                if (pending_duties.size() == 0)
                    report_fault($sformatf("result %0d/%0d/%0d clamp %0b with none expected",
                                           got.a, got.b, got.c, got.clamped));
                else
                begin
                    want = pending_duties.pop_front();
                    if (got.a !== want.a || got.b !== want.b || got.c !== want.c
                        || got.clamped !== want.clamped)
                        report_fault($sformatf("expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                               want.a, want.b, want.c, want.clamped,
                                               got.a, got.b, got.c, got.clamped));
                end
                if (got.clamped === 1'b1)
                    clamped_seen++;
            end
            // Predict with the register value in force before any write at this edge.
            if (start && !busy)
            begin
                pending_duties.push_back(typed_next ? typed_want
                                                    : modulate(quad_voltage, elec_angle, model_bus));
                accepted++;
            end
            if (cfg_we)
                model_bus = cfg_wdata;
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 LIMIT, pending_duties.size());
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [15:0] phase_bus [8];
        int          phase_idle [4];
        logic [15:0] q;
        logic [15:0] ang;
        int          h;
        int          qi;
        int          pct;

        phase_bus  = '{16'd3072, 16'd65535, 16'd1, 16'd256, 16'd0, 16'd0, 16'd0, 16'd40000};
        phase_bus[4] = 16'($urandom);
        phase_bus[6] = 16'($urandom_range(600, 2));
        phase_idle = '{0, 49, 0, 21};

        // Reset value of the bus voltage first, then the clamp edges and quadrants.
        add_typed(16'h0000, 16'h0000, '{8'd127, 8'd127, 8'd127, 1'b0});
        add_typed(16'h0000, 16'hFFFF, '{8'd127, 8'd127, 8'd127, 1'b0});
        add_cmd(16'd1536, 16'h0000);
        add_cmd(16'd1537, 16'h4000);
        add_cmd(16'hFA00, 16'h8000);
        add_cmd(16'hF9FF, 16'hC000);
        add_cmd(16'h7FFF, 16'h2000);
        add_cmd(16'h8000, 16'h3FFF);
        add_bus(16'd256);
        add_typed(16'h7FFF, 16'h4000, '{8'd0, 8'd191, 8'd191, 1'b1});
        add_typed(16'h7FFF, 16'hC000, '{8'd255, 8'd63, 8'd63, 1'b1});
        add_cmd(16'h8000, 16'h0000);
        add_cmd(16'd128, 16'h1555);
        // With no bus voltage every command is forced to zero.
        add_bus(16'd0);
        add_typed(16'h7FFF, 16'h1234, '{8'd0, 8'd0, 8'd0, 1'b1});
        add_typed(16'h0000, 16'h8000, '{8'd0, 8'd0, 8'd0, 1'b0});
        add_typed(16'h8000, 16'hFFFF, '{8'd0, 8'd0, 8'd0, 1'b1});
        add_bus(16'd65535);
        add_typed(16'h0000, 16'h0000, '{8'd127, 8'd127, 8'd127, 1'b0});
        add_cmd(16'h7FFF, 16'h4000);
        add_cmd(16'h8000, 16'hC000);
        add_bus(16'd1);
        add_cmd(16'h0001, 16'h0000);
        add_typed(16'h0000, 16'h5555, '{8'd127, 8'd127, 8'd127, 1'b0});
        add_cmd(16'hFFFF, 16'hAAAA);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_BUS)
                set_bus(directed_rows[i].value);
            else
                issue(directed_rows[i].value, directed_rows[i].ang, directed_rows[i].typed,
                      directed_rows[i].want, 0);
        end

        for (int p = 0; p < 8; p++)
        begin
            set_bus(phase_bus[p]);
            pct = phase_idle[p % 4];
            h   = int'(phase_bus[p] >> 1);
            repeat (119)
            begin
                q   = 16'($urandom);
                ang = 16'($urandom);
                case ($urandom_range(9))
                    4, 5:
                    begin
                        // Around the clamp threshold, either sign.
                        qi = h + int'($urandom_range(2)) - 1;
                        if ($urandom_range(1))
                            qi = -qi;
                        q = qi[15:0];
                    end
                    6:
                    begin
                        qi  = int'($urandom_range(16)) - 8;
                        q   = qi[15:0];
                        ang = (16'($urandom_range(3)) << 14) + 16'($urandom_range(2)) - 16'd1;
                    end
                    7:
                        q = $urandom_range(1) ? 16'h7FFF : 16'h8000;
                    8, 9:
                    begin
                        qi = int'($urandom_range(h));
                        if ($urandom_range(1))
                            qi = -qi;
                        q = qi[15:0];
                    end
                    default:
                        ;
                endcase
                issue(q, ang, 1'b0, '0, pct);
            end
        end

        start <= 1'b0;
        while (pending_duties.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d commands over %0d bus voltage writes, zero and full scale.",
                 accepted, bus_settings);
        $display("%0d results came back clamped; %0d faults counted.", clamped_seen, faults);
        if (faults == 0 && pending_duties.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
